// File: hdl/gpx_pkg.sv
// shared types, constants and codes for the port expander shadow block
`default_nettype none

package gpx_pkg;

    // bank geometry
    localparam int NUM_EXPANDERS = 4;
    localparam int PIN_BASE      = 30;
    localparam int PIN_SPAN      = 16 * NUM_EXPANDERS;
    localparam int WORD_W        = 16;
    localparam int BIT_W         = 4;
    localparam int EXP_W         = 2;

    // request codes
    localparam logic [2:0] REQ_SET_OUT  = 3'd0;
    localparam logic [2:0] REQ_SET_DIR  = 3'd1;
    localparam logic [2:0] REQ_SAMPLE   = 3'd2;
    localparam logic [2:0] REQ_QUERY    = 3'd3;
    localparam logic [2:0] REQ_LOAD_DIR = 3'd4;
    localparam logic [2:0] REQ_LOAD_OUT = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_CHANGE = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    // device register selects
    localparam logic TREG_OUTPUT = 1'b0;
    localparam logic TREG_DIR    = 1'b1;

    // status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_PIN = 1'b1;

    // configuration register indexes
    localparam logic CFG_MASK_ENABLE = 1'b0;
    localparam logic CFG_MASKED_PIN  = 1'b1;

    // shadow word selects
    localparam logic [1:0] SH_INPUT  = 2'd0;
    localparam logic [1:0] SH_OUTPUT = 2'd1;
    localparam logic [1:0] SH_DIR    = 2'd2;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [7:0]        pin_number;
        logic              pin_value;
        logic [EXP_W-1:0]  expander_index;
        logic [WORD_W-1:0] data_word;
    } request_t;

    typedef struct packed {
        logic              status;
        logic [1:0]        result_kind;
        logic [EXP_W-1:0]  target_expander;
        logic              target_register;
        logic [WORD_W-1:0] write_word;
        logic [6:0]        changed_pin;
        logic              level;
        logic              output_level;
        logic              is_output;
        logic              last;
    } result_t;

    // shadow store write and read groups
    typedef struct packed {
        logic              en;
        logic [1:0]        sel;
        logic [EXP_W-1:0]  exp;
        logic [WORD_W-1:0] word;
    } shadow_wr_t;

    typedef struct packed {
        logic [WORD_W-1:0] in_word;
        logic [WORD_W-1:0] out_word;
        logic [WORD_W-1:0] dir_word;
    } shadow_rd_t;

    // scan unit control and status
    typedef struct packed {
        logic              load;
        logic              step;
        logic [WORD_W-1:0] toggled;
        logic [WORD_W-1:0] levels;
    } scan_ctl_t;

    typedef struct packed {
        logic             hit;
        logic             lvl;
        logic             last;
        logic [BIT_W-1:0] bit_idx;
    } scan_stat_t;

endpackage

`default_nettype wire

// File: hdl/gpx_shadow.sv
// input, output and direction shadow words, one set per expander
`default_nettype none

module gpx_shadow
    import gpx_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [EXP_W-1:0] rd_exp,
    input  wire shadow_wr_t       wr,
    output shadow_rd_t            rd
);

    logic [WORD_W-1:0] in_reg  [NUM_EXPANDERS];
    logic [WORD_W-1:0] out_reg [NUM_EXPANDERS];
    logic [WORD_W-1:0] dir_reg [NUM_EXPANDERS];

    // word updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_EXPANDERS; i++)
            begin
                in_reg[i]  <= '1;
                out_reg[i] <= '0;
                dir_reg[i] <= '1;
            end
        end
        else if (wr.en)
        begin
            case (wr.sel)
                SH_INPUT:  in_reg[wr.exp]  <= wr.word;
                SH_OUTPUT: out_reg[wr.exp] <= wr.word;
                SH_DIR:    dir_reg[wr.exp] <= wr.word;
                default:   ;
            endcase
        end
    end

    // read of the addressed expander
    assign rd.in_word  = in_reg[rd_exp];
    assign rd.out_word = out_reg[rd_exp];
    assign rd.dir_word = dir_reg[rd_exp];

endmodule

`default_nettype wire

// File: hdl/gpx_scan.sv
// bit scanner that walks a toggle word one position per cycle while step is set
`default_nettype none

module gpx_scan
    import gpx_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire scan_ctl_t ctl,
    output scan_stat_t     stat
);

    logic [WORD_W-1:0] tog_reg;
    logic [WORD_W-1:0] lvl_reg;
    logic [BIT_W-1:0]  cnt_reg;

    // load or shift the working words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tog_reg <= '0;
            lvl_reg <= '0;
            cnt_reg <= '0;
        end
        else if (ctl.load)
        begin
            tog_reg <= ctl.toggled;
            lvl_reg <= ctl.levels;
            cnt_reg <= '0;
        end
        else if (ctl.step)
        begin
            tog_reg <= tog_reg >> 1;
            lvl_reg <= lvl_reg >> 1;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // current position status
    assign stat.hit     = tog_reg[0];
    assign stat.lvl     = lvl_reg[0];
    assign stat.last    = (tog_reg[WORD_W-1:1] == '0);
    assign stat.bit_idx = cnt_reg;

endmodule

`default_nettype wire

// File: hdl/gpio_expander_shadow_change_detect.sv
// top level: request sequencer, configuration and result register
// a set or query result is registered from the exec state, after decode follows start
// a sample's change events follow from the scan state, one bit position per cycle
// a sample with changes keeps the block busy while the one-bit-a-cycle scanner
// walks up to the highest toggled bit
// reset: shadows go to input all ones, output zeros, direction all ones;
// mask_enable resets to 1 and masked_pin to 0; results cannot be stalled
`default_nettype none

module gpio_expander_shadow_change_detect
    import gpx_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire request_t   request,
    output logic            result_valid,
    output result_t         result,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_DECODE, ST_EXEC, ST_SCAN} state_t;

    state_t            state_reg, state_next;
    request_t          req_reg, req_next;
    logic              pin_ok_reg, pin_ok_next;
    logic [EXP_W-1:0]  pin_exp_reg, pin_exp_next;
    logic [BIT_W-1:0]  pin_bit_reg, pin_bit_next;
    logic              mk_ok_reg, mk_ok_next;
    logic [EXP_W-1:0]  mk_exp_reg, mk_exp_next;
    logic [BIT_W-1:0]  mk_bit_reg, mk_bit_next;
    result_t           result_reg, result_next;
    logic              result_valid_reg, result_valid_next;
    logic              mask_en_reg;
    logic [7:0]        masked_pin_reg;

    logic [8:0]        pin_off;
    logic [8:0]        mk_off;
    logic [EXP_W-1:0]  rd_exp;
    logic              exp_ok;
    logic [WORD_W-1:0] bit_sel;
    logic [WORD_W-1:0] mask_word;
    logic [WORD_W-1:0] old_masked;
    logic [WORD_W-1:0] new_masked;
    logic [WORD_W-1:0] toggled;
    shadow_wr_t        sh_wr;
    shadow_rd_t        sh_rd;
    scan_ctl_t         scan_ctl;
    scan_stat_t        scan_stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_en_reg    <= 1'b1;
            masked_pin_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MASK_ENABLE: mask_en_reg    <= cfg_data[0];
                CFG_MASKED_PIN:  masked_pin_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // shadow store and bit scanner
    gpx_shadow u_shadow (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_exp (rd_exp),
        .wr     (sh_wr),
        .rd     (sh_rd)
    );

    gpx_scan u_scan (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (scan_ctl),
        .stat (scan_stat)
    );

    // pin offsets from the base
    assign pin_off = {1'b0, req_reg.pin_number} - 9'(PIN_BASE);
    assign mk_off  = {1'b0, masked_pin_reg} - 9'(PIN_BASE);

    // shadow address and sample masking
    assign rd_exp = (req_reg.req_type == REQ_SET_OUT || req_reg.req_type == REQ_SET_DIR
                     || req_reg.req_type == REQ_QUERY) ? pin_exp_reg
                                                       : req_reg.expander_index;
    assign exp_ok     = ({2'b00, req_reg.expander_index} < 4'(NUM_EXPANDERS));
    assign bit_sel    = WORD_W'(1) << pin_bit_reg;
    assign mask_word  = (mask_en_reg && mk_ok_reg && mk_exp_reg == req_reg.expander_index)
                        ? ~(WORD_W'(1) << mk_bit_reg) : '1;
    assign old_masked = sh_rd.in_word & mask_word;
    assign new_masked = req_reg.data_word & mask_word;
    assign toggled    = old_masked ^ new_masked;

    // sequencer next state
    always_comb
    begin
        state_next        = state_reg;
        req_next          = req_reg;
        pin_ok_next       = pin_ok_reg;
        pin_exp_next      = pin_exp_reg;
        pin_bit_next      = pin_bit_reg;
        mk_ok_next        = mk_ok_reg;
        mk_exp_next       = mk_exp_reg;
        mk_bit_next       = mk_bit_reg;
        result_next       = '0;
        result_valid_next = 1'b0;
        sh_wr             = '0;
        scan_ctl          = '0;
        scan_ctl.toggled  = toggled;
        scan_ctl.levels   = new_masked;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                pin_ok_next  = (req_reg.pin_number >= 8'(PIN_BASE))
                               && (pin_off < 9'(PIN_SPAN));
                pin_exp_next = pin_off[BIT_W+EXP_W-1:BIT_W];
                pin_bit_next = pin_off[BIT_W-1:0];
                mk_ok_next   = (masked_pin_reg >= 8'(PIN_BASE))
                               && (mk_off < 9'(PIN_SPAN));
                mk_exp_next  = mk_off[BIT_W+EXP_W-1:BIT_W];
                mk_bit_next  = mk_off[BIT_W-1:0];
                state_next   = ST_EXEC;
            end

            ST_EXEC:
            begin
                state_next = ST_IDLE;
                case (req_reg.req_type)
                    REQ_SET_OUT, REQ_SET_DIR:
                    begin
                        result_valid_next           = 1'b1;
                        result_next.result_kind     = KIND_WRITE;
                        result_next.last            = 1'b1;
                        result_next.target_register =
                            (req_reg.req_type == REQ_SET_DIR) ? TREG_DIR : TREG_OUTPUT;
                        if (!pin_ok_reg)
                        begin
                            result_next.status = STATUS_PIN;
                        end
                        else
                        begin
                            sh_wr.en  = 1'b1;
                            sh_wr.exp = pin_exp_reg;
                            if (req_reg.req_type == REQ_SET_OUT)
                            begin
                                sh_wr.sel  = SH_OUTPUT;
                                sh_wr.word = req_reg.pin_value ? (sh_rd.out_word | bit_sel)
                                                               : (sh_rd.out_word & ~bit_sel);
                            end
                            else
                            begin
                                // direction bit 1 means input
                                sh_wr.sel  = SH_DIR;
                                sh_wr.word = req_reg.pin_value ? (sh_rd.dir_word & ~bit_sel)
                                                               : (sh_rd.dir_word | bit_sel);
                            end
                            result_next.status          = STATUS_OK;
                            result_next.target_expander = pin_exp_reg;
                            result_next.write_word      = sh_wr.word;
                        end
                    end

                    REQ_QUERY:
                    begin
                        result_valid_next       = 1'b1;
                        result_next.result_kind = KIND_QUERY;
                        result_next.last        = 1'b1;
                        if (!pin_ok_reg)
                        begin
                            result_next.status = STATUS_PIN;
                        end
                        else
                        begin
                            result_next.status          = STATUS_OK;
                            result_next.target_expander = pin_exp_reg;
                            result_next.level           = sh_rd.in_word[pin_bit_reg];
                            result_next.output_level    = sh_rd.out_word[pin_bit_reg];
                            result_next.is_output       = ~sh_rd.dir_word[pin_bit_reg];
                        end
                    end

                    REQ_SAMPLE:
                    begin
                        if (exp_ok)
                        begin
                            sh_wr.en      = 1'b1;
                            sh_wr.sel     = SH_INPUT;
                            sh_wr.exp     = req_reg.expander_index;
                            sh_wr.word    = new_masked;
                            scan_ctl.load = 1'b1;
                            if (toggled != '0)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                    end

                    REQ_LOAD_DIR, REQ_LOAD_OUT:
                    begin
                        if (exp_ok)
                        begin
                            sh_wr.en   = 1'b1;
                            sh_wr.sel  = (req_reg.req_type == REQ_LOAD_DIR) ? SH_DIR
                                                                            : SH_OUTPUT;
                            sh_wr.exp  = req_reg.expander_index;
                            sh_wr.word = req_reg.data_word;
                        end
                    end

                    default:
                    begin
                    end
                endcase
            end

            ST_SCAN:
            begin
                // one bit position per cycle, an event on each toggled bit
                scan_ctl.step = 1'b1;
                if (scan_stat.hit)
                begin
                    result_valid_next           = 1'b1;
                    result_next.status          = STATUS_OK;
                    result_next.result_kind     = KIND_CHANGE;
                    result_next.target_expander = req_reg.expander_index;
                    result_next.changed_pin     = 7'(PIN_BASE)
                        + {1'b0, req_reg.expander_index, scan_stat.bit_idx};
                    result_next.level           = scan_stat.lvl;
                    result_next.last            = scan_stat.last;
                    if (scan_stat.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
            pin_ok_reg       <= 1'b0;
            mk_ok_reg        <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            pin_ok_reg       <= pin_ok_next;
            mk_ok_reg        <= mk_ok_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        pin_exp_reg <= pin_exp_next;
        pin_bit_reg <= pin_bit_next;
        mk_exp_reg  <= mk_exp_next;
        mk_bit_reg  <= mk_bit_next;
        result_reg  <= result_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire
